// ===== hdl/stepper_move_ramp_controller_core_macros.svh =====
// Assertion macros of the stepper move ramp controller checker.
`ifndef STEPPER_MOVE_RAMP_CONTROLLER_CORE_MACROS_SVH
`define STEPPER_MOVE_RAMP_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smrc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smrc check failed");

`endif

// ===== hdl/smrc_pkg.sv =====
// Types, constants and codes of the stepper move ramp controller.
`timescale 1ns / 1ps
package smrc_pkg;

    localparam int POS_BITS   = 16;
    localparam int WIDTH_BITS = 16;
    localparam int GOAL_W     = 16;
    localparam int VEL_W      = 10;
    localparam int ACCEL_W    = 10;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int STATUS_W   = 2;

    localparam int PULSE_SCALE = 5000;
    localparam int DIV_NUM     = 2 * PULSE_SCALE;
    localparam int NUM_BITS    = $clog2(DIV_NUM + (1 << VEL_W));
    localparam int DEN_BITS    = VEL_W + 1;
    localparam int CNT_W       = $clog2(NUM_BITS + 1);

    localparam int CMP_BITS  = (POS_BITS > CFG_W) ? POS_BITS : CFG_W;
    localparam int EXT_BITS  = (NUM_BITS > WIDTH_BITS) ? NUM_BITS : WIDTH_BITS;
    localparam int RAMP_BITS = (WIDTH_BITS > ACCEL_W) ? WIDTH_BITS : ACCEL_W;
    localparam int CLP_BITS  = (WIDTH_BITS > CFG_W) ? WIDTH_BITS : CFG_W;

    localparam logic CMD_START = 1'b1;

    // Register reset values
    localparam logic [ACCEL_W-1:0] RST_ACCEL       = ACCEL_W'(1);
    localparam logic [CFG_W-1:0]   RST_MIN_PW      = CFG_W'(100);
    localparam logic [CFG_W-1:0]   RST_MAX_PW      = CFG_W'(5000);
    localparam logic [CFG_W-1:0]   RST_RAMP_START  = CFG_W'(2000);
    localparam logic [VEL_W-1:0]   RST_SPEED_LIMIT = VEL_W'(10);
    localparam logic [CFG_W-1:0]   RST_STROKE      = CFG_W'(10000);
    localparam logic [CFG_W-1:0]   RST_SAFETY      = CFG_W'(100);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RAMP,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_REJECT  = 2'd1,
        STAT_LIMIT   = 2'd2,
        STAT_REACHED = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL       = 3'd0,
        CFG_MIN_PW      = 3'd1,
        CFG_MAX_PW      = 3'd2,
        CFG_RAMP_START  = 3'd3,
        CFG_SPEED_LIMIT = 3'd4,
        CFG_STROKE      = 3'd5,
        CFG_SAFETY      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [VEL_W-1:0] vel;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [NUM_BITS-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hdl/smrc_if.sv =====
// Valid/ready channel interfaces: move request, move response, register write.
`timescale 1ns / 1ps
interface smrc_req_if import smrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [GOAL_W-1:0] target_pos;
    logic [VEL_W-1:0]  velocity_mm_s;

    modport source (output valid, command, target_pos, velocity_mm_s, input ready);
    modport sink   (input valid, command, target_pos, velocity_mm_s, output ready);
endinterface

interface smrc_rsp_if import smrc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  step_level;
    logic                  direction;
    logic [WIDTH_BITS-1:0] pulse_width;
    logic [POS_BITS-1:0]   position;
    logic                  moving;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, step_level, direction, pulse_width, position, moving,
                    status, input ready);
    modport sink   (input valid, step_level, direction, pulse_width, position, moving,
                    status, output ready);
endinterface

interface smrc_cfg_if import smrc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/stepper_move_ramp_controller_core.sv =====
// Top level of the stepper move ramp controller: sequencer, move state and registers.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------------------
//   i_req    | in  | valid/ready        | command, target_pos, velocity_mm_s
//   o_rsp    | out | valid/ready        | step_level, direction, pulse_width, position,
//            |     |                    | moving, status
//   i_cfg    | in  | valid/ready (=1)   | index, data
//
// A tick request that steps passes check, ramp, clamp and output before its response is
// valid; a tick that finds the block idle or stops the move passes check and output. A
// start request whose goal passes the window check passes check, 14 divider steps plus
// one to apply, and output; a rejected one passes check and output. The bit-serial
// divider that turns velocity into pulse width sets the length of the start path.
// One request is in flight at a time; i_req.ready stays low until the response is
// taken. Synchronous active-low reset restores the config registers and move state.
`timescale 1ns / 1ps
module stepper_move_ramp_controller_core import smrc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smrc_req_if.sink     i_req,
    smrc_cfg_if.sink     i_cfg,
    smrc_rsp_if.source   o_rsp
);

    // Configuration registers
    logic [ACCEL_W-1:0] r_accel;
    logic [CFG_W-1:0]   r_min_pw;
    logic [CFG_W-1:0]   r_max_pw;
    logic [CFG_W-1:0]   r_ramp_start;
    logic [VEL_W-1:0]   r_speed_lim;
    logic [CFG_W-1:0]   r_stroke;
    logic [CFG_W-1:0]   r_safety;

    // Move state
    t_state                r_state, n_state;
    t_status               r_status, n_status;
    logic [POS_BITS-1:0]   r_cur_pos, n_cur_pos;
    logic [POS_BITS-1:0]   r_tgt_pos, n_tgt_pos;
    logic [WIDTH_BITS-1:0] r_cur_w, n_cur_w;
    logic [WIDTH_BITS-1:0] r_tgt_w, n_tgt_w;
    logic                  r_dir, n_dir;
    logic                  r_step, n_step;
    logic                  r_moving, n_moving;
    logic                  r_ramping, n_ramping;

    // Captured request
    logic              r_cmd;
    logic [GOAL_W-1:0] r_goal;
    logic [VEL_W-1:0]  r_vel;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_step;
    logic                  r_out_dir;
    logic [WIDTH_BITS-1:0] r_out_w;
    logic [POS_BITS-1:0]   r_out_pos;
    logic                  r_out_moving;
    t_status               r_out_status;

    t_div_req s_div_req;
    t_div_rsp s_div_rsp;

    logic                  req_acc;
    logic                  rsp_acc;
    logic [CMP_BITS-1:0]   chk_pos;
    logic [CMP_BITS-1:0]   win_hi;
    logic                  win_ok;
    logic [WIDTH_BITS-1:0] div_w;
    logic [WIDTH_BITS-1:0] gap;
    logic                  gap_le_accel;
    logic [RAMP_BITS-1:0]  ramp_sub;
    logic [WIDTH_BITS-1:0] clp_lo;
    logic [WIDTH_BITS-1:0] clp_w;
    logic [POS_BITS-1:0]   pos_next;

    assign req_acc = i_req.valid && i_req.ready;
    assign rsp_acc = o_rsp.valid && o_rsp.ready;

    // Hold off new requests while one is in work or its response waits
    assign i_req.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign i_cfg.ready = 1'b1;

    smrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    // Safe window [safety, stroke - safety); empty when safety >= stroke.
    // Start checks the goal, tick checks the current position.
    assign chk_pos = (r_cmd == CMD_START) ? CMP_BITS'(r_goal) : CMP_BITS'(r_cur_pos);
    assign win_hi  = CMP_BITS'(r_stroke) - CMP_BITS'(r_safety);
    assign win_ok  = (r_safety < r_stroke) && (chk_pos >= CMP_BITS'(r_safety))
                     && (chk_pos < win_hi);

    // Width from velocity; zero velocity and overflow saturate to all ones
    always_comb begin
        if (r_vel == '0) begin
            div_w = '1;
        end else if (EXT_BITS'(s_div_rsp.quot) > EXT_BITS'({WIDTH_BITS{1'b1}})) begin
            div_w = '1;
        end else begin
            div_w = WIDTH_BITS'(s_div_rsp.quot);
        end
    end

    // Ramp: step down by accel, land exactly on the goal width when the gap is small
    assign gap          = r_cur_w - r_tgt_w;
    assign gap_le_accel = (RAMP_BITS'(gap) <= RAMP_BITS'(r_accel));
    assign ramp_sub     = RAMP_BITS'(r_cur_w) - RAMP_BITS'(r_accel);

    // Clamp: min first, then max, so max wins when they cross
    assign clp_lo = (CLP_BITS'(r_cur_w) < CLP_BITS'(r_min_pw)) ? WIDTH_BITS'(r_min_pw) : r_cur_w;
    assign clp_w  = (CLP_BITS'(clp_lo) > CLP_BITS'(r_max_pw)) ? WIDTH_BITS'(r_max_pw) : clp_lo;

    assign pos_next = r_dir ? (r_cur_pos + POS_BITS'(1)) : (r_cur_pos - POS_BITS'(1));

    always_comb begin
        n_state         = r_state;
        n_status        = r_status;
        n_cur_pos       = r_cur_pos;
        n_tgt_pos       = r_tgt_pos;
        n_cur_w         = r_cur_w;
        n_tgt_w         = r_tgt_w;
        n_dir           = r_dir;
        n_step          = r_step;
        n_moving        = r_moving;
        n_ramping       = r_ramping;
        s_div_req.start = 1'b0;
        s_div_req.vel   = r_vel;

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_OUT;
                if (r_cmd == CMD_START) begin
                    if (!win_ok) begin
                        // Rejected goal leaves any running move alone
                        n_status = STAT_REJECT;
                    end else begin
                        n_status        = STAT_OK;
                        s_div_req.start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end else if (!r_moving) begin
                    n_status = STAT_OK;
                end else if (!win_ok) begin
                    // Out of window: stop, keep the step line level
                    n_moving = 1'b0;
                    n_status = STAT_LIMIT;
                end else if (r_cur_pos == r_tgt_pos) begin
                    n_step   = 1'b0;
                    n_moving = 1'b0;
                    n_status = STAT_REACHED;
                end else begin
                    n_status = STAT_OK;
                    n_state  = ST_RAMP;
                end
            end
            ST_DIV: begin
                if (s_div_rsp.done) begin
                    n_tgt_pos = POS_BITS'(r_goal);
                    n_dir     = (POS_BITS'(r_goal) >= r_cur_pos);
                    n_tgt_w   = div_w;
                    n_moving  = 1'b1;
                    if (r_vel > r_speed_lim) begin
                        n_ramping = 1'b1;
                        n_cur_w   = WIDTH_BITS'(r_ramp_start);
                    end else begin
                        n_ramping = 1'b0;
                        n_cur_w   = div_w;
                    end
                    n_state = ST_OUT;
                end
            end
            ST_RAMP: begin
                if (r_ramping) begin
                    if (r_cur_w > r_tgt_w) begin
                        if (gap_le_accel) begin
                            n_cur_w   = r_tgt_w;
                            n_ramping = 1'b0;
                        end else begin
                            n_cur_w = WIDTH_BITS'(ramp_sub);
                        end
                    end else begin
                        n_ramping = 1'b0;
                    end
                end
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_cur_w = clp_w;
                n_step  = !r_step;
                // Count position on each rising edge of the step line
                if (!r_step) begin
                    n_cur_pos = pos_next;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_status    <= STAT_OK;
            r_cur_pos   <= '0;
            r_tgt_pos   <= '0;
            r_cur_w     <= WIDTH_BITS'(RST_RAMP_START);
            r_tgt_w     <= '0;
            r_dir       <= 1'b1;
            r_step      <= 1'b0;
            r_moving    <= 1'b0;
            r_ramping   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_cur_pos <= n_cur_pos;
            r_tgt_pos <= n_tgt_pos;
            r_cur_w   <= n_cur_w;
            r_tgt_w   <= n_tgt_w;
            r_dir     <= n_dir;
            r_step    <= n_step;
            r_moving  <= n_moving;
            r_ramping <= n_ramping;
            if (r_state == ST_OUT) begin
                r_out_valid <= 1'b1;
            end else if (rsp_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register writes; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= RST_ACCEL;
            r_min_pw     <= RST_MIN_PW;
            r_max_pw     <= RST_MAX_PW;
            r_ramp_start <= RST_RAMP_START;
            r_speed_lim  <= RST_SPEED_LIMIT;
            r_stroke     <= RST_STROKE;
            r_safety     <= RST_SAFETY;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ACCEL:       r_accel      <= i_cfg.data[ACCEL_W-1:0];
                CFG_MIN_PW:      r_min_pw     <= i_cfg.data;
                CFG_MAX_PW:      r_max_pw     <= i_cfg.data;
                CFG_RAMP_START:  r_ramp_start <= i_cfg.data;
                CFG_SPEED_LIMIT: r_speed_lim  <= i_cfg.data[VEL_W-1:0];
                CFG_STROKE:      r_stroke     <= i_cfg.data;
                CFG_SAFETY:      r_safety     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Capture the request and load the response payload
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_cmd  <= i_req.command;
            r_goal <= i_req.target_pos;
            r_vel  <= i_req.velocity_mm_s;
        end
        if (r_state == ST_OUT) begin
            r_out_step   <= r_step;
            r_out_dir    <= r_dir;
            r_out_w      <= r_cur_w;
            r_out_pos    <= r_cur_pos;
            r_out_moving <= r_moving;
            r_out_status <= r_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.step_level  = r_out_step;
    assign o_rsp.direction   = r_out_dir;
    assign o_rsp.pulse_width = r_out_w;
    assign o_rsp.position    = r_out_pos;
    assign o_rsp.moving      = r_out_moving;
    assign o_rsp.status      = r_out_status;

endmodule

// ===== hdl/smrc_div.sv =====
// Bit-serial restoring divider: (10000 + v) / (2 v), one quotient bit per cycle.
`timescale 1ns / 1ps
module smrc_div import smrc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;

    logic [DEN_BITS:0] rem_sh;
    logic [DEN_BITS:0] rem_diff;
    logic              q_bit;

    assign rem_sh   = {r_rem, r_num[NUM_BITS-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_den});
    assign rem_diff = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CNT_W'(NUM_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in where numerator bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= NUM_BITS'(DIV_NUM) + NUM_BITS'(i_req.vel);
            r_den <= {i_req.vel, 1'b0};
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_BITS-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

// ===== hdl/smrc_chk.sv =====
// Port-level checker for the stepper move ramp controller, bound to the top level.
`timescale 1ns / 1ps
`include "stepper_move_ramp_controller_core_macros.svh"
module smrc_chk import smrc_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic                i_rsp_step_level,
    input logic                i_rsp_moving,
    input logic [STATUS_W-1:0] i_rsp_status
);

    // A stalled response holds
    `SMRC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status))

    // No new request while a response waits
    `SMRC_ASSERT_IMPL(a_no_req_while_rsp, i_clk, i_rst_n, i_rsp_valid, !i_req_ready)

    // One request in flight at a time
    `SMRC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // Goal reached ends the move with the step line low
    `SMRC_ASSERT_IMPL(a_reached_stops, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == STAT_REACHED), !i_rsp_moving && !i_rsp_step_level)

    // Limit hit ends the move
    `SMRC_ASSERT_IMPL(a_limit_stops, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == STAT_LIMIT), !i_rsp_moving)

endmodule

bind stepper_move_ramp_controller_core smrc_chk u_smrc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_step_level (o_rsp.step_level),
    .i_rsp_moving     (o_rsp.moving),
    .i_rsp_status     (o_rsp.status)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the stepper move ramp controller core.
`timescale 1ns / 1ps
module testbench;
    import smrc_pkg::*;

    // One response per move request, compared field by field.
    typedef struct packed {
        logic                  step_level;
        logic                  direction;
        logic [WIDTH_BITS-1:0] pulse_width;
        logic [POS_BITS-1:0]   position;
        logic                  moving;
        t_status               status;
    } t_move_result;

    // One line of the directed table: a register write or a move request, with the
    // response typed in where it is obvious and left to the predictor otherwise.
    typedef struct {
        bit                is_write;
        t_cfg_idx          reg_index;
        logic [CFG_W-1:0]  reg_data;
        logic              cmd;
        logic [GOAL_W-1:0] goal;
        logic [VEL_W-1:0]  vel;
        bit                typed;
        t_move_result      want;
    } t_directed_row;

    localparam logic         CMD_TICK      = ~CMD_START;
    localparam t_move_result UNTYPED       = '0;
    localparam int           REG_COUNT     = int'(CFG_SAFETY) + 1;
    localparam int           DIRECTED_ROWS = 27;
    localparam int           PHASES        = 6;
    localparam int           CYCLE_LIMIT   = 400000;
    localparam int           SETTLE_CYCLES = 24;

    logic i_clk;
    logic i_rst_n;

    smrc_req_if req_bus ();
    smrc_cfg_if cfg_bus ();
    smrc_rsp_if rsp_bus ();

    stepper_move_ramp_controller_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    // Register copies held by the predictor.
    logic [ACCEL_W-1:0]    reg_accel;
    logic [CFG_W-1:0]      reg_min_width;
    logic [CFG_W-1:0]      reg_max_width;
    logic [CFG_W-1:0]      reg_ramp_start;
    logic [VEL_W-1:0]      reg_speed_limit;
    logic [CFG_W-1:0]      reg_stroke;
    logic [CFG_W-1:0]      reg_safety;

    // Move state held by the predictor.
    logic [POS_BITS-1:0]   model_position;
    logic [POS_BITS-1:0]   model_target;
    logic [WIDTH_BITS-1:0] model_width;
    logic [WIDTH_BITS-1:0] model_goal_width;
    logic                  model_extend;
    logic                  model_step;
    logic                  model_moving;
    logic                  model_ramping;

    t_move_result expected_moves[$];

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 55;
    int          requests_sent = 0;
    int          starts_sent   = 0;
    int          ticks_sent    = 0;
    int          responses_checked = 0;
    int          mismatch_count = 0;
    int          settings_used  = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int          cycle_count;

    // Directed table: reset state, window edges, both speed regimes, zero speed,
    // limit stop, goal reached, retarget in mid-move with a direction change.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    1,
          '{1'b0, 1'b1, 16'd2000,  16'd0, 1'b0, STAT_OK}},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd0,     10'd1,    1,
          '{1'b0, 1'b1, 16'd2000,  16'd0, 1'b0, STAT_REJECT}},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd65535, 10'd1023, 1,
          '{1'b0, 1'b1, 16'd2000,  16'd0, 1'b0, STAT_REJECT}},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd9900,  10'd5,    1,
          '{1'b0, 1'b1, 16'd2000,  16'd0, 1'b0, STAT_REJECT}},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd100,   10'd10,   1,
          '{1'b0, 1'b1, 16'd500,   16'd0, 1'b1, STAT_OK}},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    1,
          '{1'b0, 1'b1, 16'd500,   16'd0, 1'b0, STAT_LIMIT}},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    1,
          '{1'b0, 1'b1, 16'd500,   16'd0, 1'b0, STAT_OK}},
        '{1, CFG_SAFETY, 16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd0,     10'd0,    1,
          '{1'b0, 1'b1, 16'd65535, 16'd0, 1'b1, STAT_OK}},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    1,
          '{1'b0, 1'b1, 16'd65535, 16'd0, 1'b0, STAT_REACHED}},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd4,     10'd1023, 0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd9999,  10'd11,   0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd10000, 10'd512,  0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_START, 16'd2,     10'd1,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED},
        '{0, CFG_ACCEL,  16'd0, CMD_TICK,  16'd0,     10'd0,    0, UNTYPED}
    };

    // Register settings of the random phases, in index order:
    // accel, min width, max width, ramp start, speed limit, stroke, safety.
    // The later phases hit the extremes: empty window, one-step stroke, min above max.
    logic [CFG_W-1:0] phase_regs [PHASES][REG_COUNT] = '{
        '{16'd200,  16'd100,   16'd5000,  16'd2000,  16'd10,   16'd10000, 16'd0},
        '{16'd1023, 16'd1,     16'd65535, 16'd65535, 16'd1,    16'd65535, 16'd0},
        '{16'd7,    16'd3000,  16'd200,   16'd1,     16'd1023, 16'd400,   16'd50},
        '{16'd50,   16'd20,    16'd3000,  16'd4000,  16'd100,  16'd20000, 16'd65535},
        '{16'd1,    16'd65535, 16'd1,     16'd30000, 16'd500,  16'd1,     16'd0},
        '{16'd300,  16'd150,   16'd4000,  16'd9,     16'd200,  16'd10000, 16'd100}
    };
    int phase_items [PHASES] = '{330, 250, 200, 40, 40, 240};

    // Free-running clock, 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Safe stroke window check on the current register copies.
    function automatic bit in_stroke_window(input logic [POS_BITS-1:0] pos);
        if (reg_safety >= reg_stroke) begin
            return 1'b0;
        end
        return pos >= reg_safety && pos < reg_stroke - reg_safety;
    endfunction

    // Rounded 5000/v in whole microseconds, saturating at the width range.
    function automatic logic [WIDTH_BITS-1:0] width_for_speed(input logic [VEL_W-1:0] vel);
        int unsigned quotient;
        if (vel == '0) begin
            return '1;
        end
        quotient = (2 * PULSE_SCALE + int'(vel)) / (2 * int'(vel));
        if (quotient > (2 ** WIDTH_BITS) - 1) begin
            return '1;
        end
        return WIDTH_BITS'(quotient);
    endfunction

    // Advance the move state by one request and return the response it owes.
    function automatic t_move_result predict_move(input logic cmd,
                                                  input logic [GOAL_W-1:0] goal,
                                                  input logic [VEL_W-1:0] vel);
        t_move_result          res;
        logic [WIDTH_BITS-1:0] gap;
        t_status               status;
        status = STAT_OK;
        if (cmd == CMD_START) begin
            if (!in_stroke_window(POS_BITS'(goal))) begin
                // rejected goal leaves everything alone, even a move in progress
                status = STAT_REJECT;
            end else begin
                model_target     = POS_BITS'(goal);
                model_extend     = (model_target >= model_position);
                model_goal_width = width_for_speed(vel);
                model_ramping    = (vel > reg_speed_limit);
                model_width      = model_ramping ? WIDTH_BITS'(reg_ramp_start)
                                                 : model_goal_width;
                model_moving     = 1'b1;
            end
        end else if (model_moving) begin
            if (!in_stroke_window(model_position)) begin
                // out of window: stop without stepping, step line holds its level
                model_moving = 1'b0;
                status       = STAT_LIMIT;
            end else if (model_position == model_target) begin
                model_step   = 1'b0;
                model_moving = 1'b0;
                status       = STAT_REACHED;
            end else begin
                if (model_ramping) begin
                    if (model_width > model_goal_width) begin
                        gap = model_width - model_goal_width;
                        model_width -= (gap < reg_accel) ? gap : WIDTH_BITS'(reg_accel);
                    end
                    if (model_width <= model_goal_width) begin
                        model_ramping = 1'b0;
                    end
                end
                // min first, then max: max wins when the two cross
                if (model_width < reg_min_width) begin
                    model_width = WIDTH_BITS'(reg_min_width);
                end
                if (model_width > reg_max_width) begin
                    model_width = WIDTH_BITS'(reg_max_width);
                end
                model_step = ~model_step;
                if (model_step) begin
                    model_position = model_extend ? model_position + 1'b1
                                                  : model_position - 1'b1;
                end
            end
        end
        res.step_level  = model_step;
        res.direction   = model_extend;
        res.pulse_width = model_width;
        res.position    = model_position;
        res.moving      = model_moving;
        res.status      = status;
        return res;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Drive one move request, hold it until taken, then queue its expected response.
    task automatic send_move_request(input logic cmd, input logic [GOAL_W-1:0] goal,
                                     input logic [VEL_W-1:0] vel, input bit typed,
                                     input t_move_result want);
        t_move_result predicted;
        // random sender gaps
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.command       <= cmd;
        req_bus.target_pos    <= goal;
        req_bus.velocity_mm_s <= vel;
        do @(posedge i_clk); while (!req_bus.ready);
        // accepted at this edge: valid stays high until the caller drives the next one
        predicted = predict_move(cmd, goal, vel);
        expected_moves.push_back(typed ? want : predicted);
        status_seen[int'(predicted.status)]++;
        if (cmd == CMD_START) begin
            starts_sent++;
        end else begin
            ticks_sent++;
        end
        requests_sent++;
        // idle pattern: sender-light first, then receiver-light, then none at all
        if (requests_sent >= 750) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end else if (requests_sent >= 375) begin
            send_idle_pct = 55;
            recv_idle_pct = 27;
        end
    endtask

    // Drop the request line and hold until every pending response is back.
    task automatic wait_for_idle();
        req_bus.valid <= 1'b0;
        while (expected_moves.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write; leaves valid high so writes can go back to back.
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_ACCEL:       reg_accel       = ACCEL_W'(data);
            CFG_MIN_PW:      reg_min_width   = data;
            CFG_MAX_PW:      reg_max_width   = data;
            CFG_RAMP_START:  reg_ramp_start  = data;
            CFG_SPEED_LIMIT: reg_speed_limit = VEL_W'(data);
            CFG_STROKE:      reg_stroke      = data;
            CFG_SAFETY:      reg_safety      = data;
            default: ;
        endcase
    endtask

    // Mostly ticks while a move runs, else mostly starts near the current position, biased
    // upward so the actuator walks into the narrower windows of later phases; the rest is
    // retargets, arbitrary goals and idle ticks.
    task automatic pick_random_request(output logic cmd, output logic [GOAL_W-1:0] goal,
                                       output logic [VEL_W-1:0] vel);
        int unsigned roll;
        int          offset;
        roll   = $urandom_range(0, 99);
        offset = int'($urandom_range(0, 25)) - 5;
        cmd    = CMD_START;
        goal   = GOAL_W'(int'(model_position) + offset);
        vel    = ($urandom_range(0, 1) != 0) ? VEL_W'($urandom_range(0, 1023))
                                             : VEL_W'($urandom_range(0, reg_speed_limit));
        if (model_moving) begin
            if (roll < 86) begin
                cmd = CMD_TICK;
            end else if (roll >= 94) begin
                goal = GOAL_W'($urandom);
            end
        end else begin
            if (roll >= 88) begin
                cmd = CMD_TICK;
            end else if (roll >= 72) begin
                goal = GOAL_W'($urandom);
            end
        end
        // fields a tick ignores still carry noise
        if (cmd == CMD_TICK) begin
            goal = GOAL_W'($urandom);
            vel  = VEL_W'($urandom);
        end
    endtask

    // Response side: check each taken response, then stall at random.
    always @(posedge i_clk) begin
        t_move_result got;
        t_move_result want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = '{rsp_bus.step_level, rsp_bus.direction, rsp_bus.pulse_width,
                        rsp_bus.position, rsp_bus.moving, t_status'(rsp_bus.status)};
                if (expected_moves.size() == 0) begin
                    $display("%0t: response with nothing pending, actual status %0d",
                             $time, got.status);
                    mismatch_count++;
                end else begin
                    want = expected_moves.pop_front();
                    compare_field("step_level",  want.step_level,  got.step_level);
                    compare_field("direction",   want.direction,   got.direction);
                    compare_field("pulse_width", want.pulse_width, got.pulse_width);
                    compare_field("position",    want.position,    got.position);
                    compare_field("moving",      want.moving,      got.moving);
                    compare_field("status",      want.status,      got.status);
                    responses_checked++;
                end
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: stop a hung run.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
            @(posedge i_clk);
        end
        $display("Timeout after %0d cycles, %0d responses pending",
                 CYCLE_LIMIT, expected_moves.size());
        $display("** stepper_move_ramp_controller_core: FAILED **");
        $finish;
    end

    initial begin
        logic              cmd;
        logic [GOAL_W-1:0] goal;
        logic [VEL_W-1:0]  vel;
        int                issued;

        // Drive every input to a known value and hold reset.
        i_rst_n               = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.command       = CMD_TICK;
        req_bus.target_pos    = '0;
        req_bus.velocity_mm_s = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_ACCEL;
        cfg_bus.data          = '0;

        // Predictor starts from the reset values.
        reg_accel        = RST_ACCEL;
        reg_min_width    = RST_MIN_PW;
        reg_max_width    = RST_MAX_PW;
        reg_ramp_start   = RST_RAMP_START;
        reg_speed_limit  = RST_SPEED_LIMIT;
        reg_stroke       = RST_STROKE;
        reg_safety       = RST_SAFETY;
        model_position   = '0;
        model_target     = '0;
        model_width      = WIDTH_BITS'(RST_RAMP_START);
        model_goal_width = '0;
        model_extend     = 1'b1;
        model_step       = 1'b0;
        model_moving     = 1'b0;
        model_ramping    = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; register rows wait for the block to go idle first.
        settings_used = 1;
        foreach (directed_rows[row]) begin
            if (directed_rows[row].is_write) begin
                wait_for_idle();
                write_register(directed_rows[row].reg_index, directed_rows[row].reg_data);
                cfg_bus.valid <= 1'b0;
                settings_used++;
            end else begin
                send_move_request(directed_rows[row].cmd, directed_rows[row].goal,
                                  directed_rows[row].vel, directed_rows[row].typed,
                                  directed_rows[row].want);
            end
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_idle();
            for (int r = 0; r < REG_COUNT; r++) begin
                write_register(t_cfg_idx'(r), phase_regs[p][r]);
            end
            cfg_bus.valid <= 1'b0;
            settings_used++;
            issued = 0;
            while (issued < phase_items[p]) begin
                pick_random_request(cmd, goal, vel);
                // an idle tick does nothing, so it does not count
                if (cmd == CMD_START || model_moving) begin
                    issued++;
                end
                send_move_request(cmd, goal, vel, 1'b0, UNTYPED);
            end
        end

        // Drain, then allow a start's worth of cycles for any stray response.
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_moves.size() != 0) begin
            $display("%0t: %0d expected responses never arrived", $time,
                     expected_moves.size());
        end
        $display("Covered %0d requests (%0d starts, %0d ticks) under %0d register settings.",
                 requests_sent, starts_sent, ticks_sent, settings_used);
        $display("Checked %0d responses: %0d reached, %0d limit stops, %0d rejected goals.",
                 responses_checked, status_seen[int'(STAT_REACHED)],
                 status_seen[int'(STAT_LIMIT)], status_seen[int'(STAT_REJECT)]);
        if (mismatch_count == 0 && expected_moves.size() == 0) begin
            $display("** stepper_move_ramp_controller_core: PASSED **");
        end else begin
            $display("** stepper_move_ramp_controller_core: FAILED **");
        end
        $finish;
    end

endmodule
